FILE: sv/mcne_pkg.sv
`timescale 1ns / 1ps
package mcne_pkg;

  localparam logic [7:0] ST_NOTE_MASK  = 8'hE0;
  localparam logic [7:0] ST_NOTE_EVENT = 8'h80;
  localparam logic       ACT_MIDI      = 1'b0;
  localparam logic       ACT_TABLE     = 1'b1;

  localparam int PITCH_CLASSES = 12;
  localparam logic [6:0] VEL_MAX  = 7'd127;
  localparam logic [7:0] NOTE_MAX = 8'd127;
  localparam logic [7:0] UNITY    = 8'd128;

  localparam int OFS_W  = 6;
  localparam int GAIN_W = 9;
  localparam int PROD_W = 17;   // gain * velocity
  localparam int MUL_W  = 25;   // (gain * velocity) * wet

  localparam logic signed [9:0] OFS_HI   = 10'sd24;
  localparam logic signed [9:0] OFS_LO   = -10'sd24;
  localparam logic signed [9:0] GAIN_HI  = 10'sd256;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd128;

  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic [GAIN_W-1:0]       gain_t;

  // note mod 12 via reciprocal multiply, exact for any 8-bit note
  function automatic logic [3:0] pitch_class(input logic [7:0] note);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(note) * 16'd171;
    q = p[15:11];
    r = note - 8'(q * 8'd12);
    return r[3:0];
  endfunction

  function automatic ofs_t clamp_ofs(input logic signed [9:0] v);
    logic signed [9:0] c;
    c = v;
    if (c > OFS_HI) c = OFS_HI;
    if (c < OFS_LO) c = OFS_LO;
    return c[OFS_W-1:0];
  endfunction

  function automatic gain_t clamp_gain(input logic signed [9:0] v);
    logic signed [9:0] c;
    c = v;
    if (c < 10'sd0) c = 10'sd0;
    if (c > GAIN_HI) c = GAIN_HI;
    return c[GAIN_W-1:0];
  endfunction

endpackage

FILE: sv/mcne_in_if.sv
`timescale 1ns / 1ps
interface mcne_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic [15:0]       frame;
  logic [2:0]        byte_count;
  logic [7:0]        status;
  logic [7:0]        data_one;
  logic [7:0]        data_two;
  logic [7:0]        data_three;
  logic [6:0]        entry_index;
  logic signed [9:0] table_value;

  modport source (
    output valid, action, frame, byte_count, status, data_one, data_two,
           data_three, entry_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, action, frame, byte_count, status, data_one, data_two,
           data_three, entry_index, table_value,
    output ready
  );
endinterface

FILE: sv/mcne_out_if.sv
`timescale 1ns / 1ps
interface mcne_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_frame;
  logic [2:0]  out_byte_count;
  logic [7:0]  out_status;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic [7:0]  out_data_three;
  logic        last;

  modport source (
    output valid, out_frame, out_byte_count, out_status, out_data_one,
           out_data_two, out_data_three, last,
    input  ready
  );
  modport sink (
    input  valid, out_frame, out_byte_count, out_status, out_data_one,
           out_data_two, out_data_three, last,
    output ready
  );
endinterface

FILE: sv/mcne_ram.sv
`timescale 1ns / 1ps
module mcne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/mcne_mul.sv
`timescale 1ns / 1ps
module mcne_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mcne_pkg::PROD_W-1:0] a,
  input  logic [7:0]                   b,
  output logic [mcne_pkg::MUL_W-1:0]  p
);
  import mcne_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_W'(a) * MUL_W'(b);
    end
  end
endmodule

FILE: sv/midi_chord_note_expander_unit.sv
`timescale 1ns / 1ps
// MIDI chord note expander.
// in_chan takes one item per valid/ready handshake: a MIDI event or a table
// entry write. out_chan gives result items, last marks the final one of an
// input item. cfg_wr_en/cfg_wr_data write the wet level (Q1.7).
// Steps, with the receiver always ready:
//   table write   : taken while idle, no result.
//   other events  : one result, passed from S_PASS into the output register.
//   note events   : each kept voice is a table read plus two passes through
//                   the one shared multiplier (gain*velocity, then *wet, the
//                   root *unity) and an emit step, a dropped or skipped voice
//                   only the read and its check. A result goes out once the
//                   following kept voice is known, the final one at the end.
// in_chan.ready is high only between items. A stalled receiver holds the
// output register; the sequencer waits whenever it has a new result to hand
// over and the register is still full.
// Reset clears the wet level to unity and marks every table entry unwritten,
// so offsets read as 0 and gains as unity until written; no clearing pass.
module midi_chord_note_expander_unit #(
  parameter int VOICES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  mcne_in_if.sink    in_chan,
  mcne_out_if.source out_chan,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import mcne_pkg::*;

  localparam int DEPTH = PITCH_CLASSES * VOICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [7:0] OFS_END  = 8'(DEPTH);
  localparam logic [7:0] GAIN_END = 8'(2 * DEPTH);
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [7:0]    wet_r;
  logic [15:0]   frame_r, frame_nxt;
  logic [2:0]    count_r, count_nxt;
  logic [7:0]    status_r, status_nxt;
  logic [7:0]    d1_r, d1_nxt;
  logic [7:0]    d2_r, d2_nxt;
  logic [7:0]    d3_r, d3_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [VW-1:0] voice_r, voice_nxt;
  ofs_t          root_ofs_r, root_ofs_nxt;
  logic [6:0]    note_r, note_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [6:0]    pend_note_r, pend_note_nxt;
  logic [6:0]    pend_vel_r, pend_vel_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [15:0]   o_frame_r, o_frame_nxt;
  logic [2:0]    o_count_r, o_count_nxt;
  logic [7:0]    o_status_r, o_status_nxt;
  logic [7:0]    o_d1_r, o_d1_nxt;
  logic [7:0]    o_d2_r, o_d2_nxt;
  logic [7:0]    o_d3_r, o_d3_nxt;
  logic          o_last_r, o_last_nxt;
  logic [DEPTH-1:0] ofs_vld_r, gain_vld_r;

  logic          accept, out_free, is_note, last_voice;
  logic [7:0]    idx8, gain_idx;
  logic          ofs_we, gain_we;
  logic [AW-1:0] raddr;
  ofs_t          ofs_q, ofs_cur;
  gain_t         gain_q, gain_cur;
  logic signed [9:0] note_sum;
  logic          drop;
  logic [7:0]    wet_eff;
  logic          mul_en;
  logic [PROD_W-1:0] mul_a;
  logic [7:0]    mul_b;
  logic [MUL_W-1:0]  mul_p;
  logic [6:0]    vel;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_vld_r || out_chan.ready;
  assign is_note  = (in_chan.byte_count > 3'd2) &&
                    ((in_chan.status & ST_NOTE_MASK) == ST_NOTE_EVENT);
  assign last_voice = (voice_r == LAST_VOICE);

  // table writes
  assign idx8     = {1'b0, in_chan.entry_index};
  assign gain_idx = idx8 - OFS_END;
  assign ofs_we   = accept && (in_chan.action == ACT_TABLE) && (idx8 < OFS_END);
  assign gain_we  = accept && (in_chan.action == ACT_TABLE) &&
                    (idx8 >= OFS_END) && (idx8 < GAIN_END);

  assign raddr = AW'(base_r + AW'(voice_r));

  mcne_ram #(.WIDTH(OFS_W), .DEPTH(DEPTH)) u_ofs_ram (
    .clk   (clk),
    .we    (ofs_we),
    .waddr (AW'(idx8)),
    .wdata (clamp_ofs(in_chan.table_value)),
    .raddr (raddr),
    .rdata (ofs_q)
  );

  mcne_ram #(.WIDTH(GAIN_W), .DEPTH(DEPTH)) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (AW'(gain_idx)),
    .wdata (clamp_gain(in_chan.table_value)),
    .raddr (raddr),
    .rdata (gain_q)
  );

  // unwritten entries read as their reset values
  assign ofs_cur  = ofs_vld_r[raddr]  ? ofs_q  : '0;
  assign gain_cur = gain_vld_r[raddr] ? gain_q : GAIN_UNITY;

  assign note_sum = $signed({2'b00, d1_r}) + {{(10-OFS_W){ofs_cur[OFS_W-1]}}, ofs_cur};
  assign drop = ((voice_r != '0) && (ofs_cur == root_ofs_r)) ||
                (note_sum < 10'sd0) || (note_sum > $signed({2'b00, NOTE_MAX}));

  assign wet_eff = (wet_r > UNITY) ? UNITY : wet_r;

  // shared multiplier: gain*vel in MUL1, then product*wet (root: *128) in MUL2
  assign mul_en = (state_r == S_MUL1) || (state_r == S_MUL2);
  assign mul_a  = (state_r == S_MUL1) ? PROD_W'(gain_cur) : mul_p[PROD_W-1:0];
  assign mul_b  = (state_r == S_MUL1) ? d2_r : ((voice_r == '0) ? UNITY : wet_eff);

  mcne_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign vel = (|mul_p[MUL_W-1:21]) ? VEL_MAX : mul_p[20:14];

  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    d3_nxt        = d3_r;
    base_nxt      = base_r;
    voice_nxt     = voice_r;
    root_ofs_nxt  = root_ofs_r;
    note_nxt      = note_r;
    pend_vld_nxt  = pend_vld_r;
    pend_note_nxt = pend_note_r;
    pend_vel_nxt  = pend_vel_r;
    out_vld_nxt   = out_vld_r && !out_chan.ready;
    o_frame_nxt   = o_frame_r;
    o_count_nxt   = o_count_r;
    o_status_nxt  = o_status_r;
    o_d1_nxt      = o_d1_r;
    o_d2_nxt      = o_d2_r;
    o_d3_nxt      = o_d3_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          frame_nxt  = in_chan.frame;
          count_nxt  = in_chan.byte_count;
          status_nxt = in_chan.status;
          d1_nxt     = in_chan.data_one;
          d2_nxt     = in_chan.data_two;
          d3_nxt     = in_chan.data_three;
          if (in_chan.action == ACT_MIDI) begin
            if (is_note) begin
              base_nxt  = AW'(pitch_class(in_chan.data_one) * VOICES);
              voice_nxt = '0;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_PASS;
            end
          end
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          o_frame_nxt  = frame_r;
          o_count_nxt  = count_r;
          o_status_nxt = status_r;
          o_d1_nxt     = d1_r;
          o_d2_nxt     = d2_r;
          o_d3_nxt     = d3_r;
          o_last_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        if (voice_r == '0) begin
          root_ofs_nxt = ofs_cur;
        end
        if (drop) begin
          if (last_voice) begin
            state_nxt = S_FIN;
          end else begin
            voice_nxt = voice_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          note_nxt  = note_sum[6:0];
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // a held voice goes out only once a later kept voice exists
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            o_frame_nxt  = frame_r;
            o_count_nxt  = count_r;
            o_status_nxt = status_r;
            o_d1_nxt     = {1'b0, pend_note_r};
            o_d2_nxt     = {1'b0, pend_vel_r};
            o_d3_nxt     = d3_r;
            o_last_nxt   = 1'b0;
          end
          pend_vld_nxt  = 1'b1;
          pend_note_nxt = note_r;
          pend_vel_nxt  = vel;
          if (last_voice) begin
            state_nxt = S_FIN;
          end else begin
            voice_nxt = voice_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          o_frame_nxt  = frame_r;
          o_count_nxt  = count_r;
          o_status_nxt = status_r;
          o_d1_nxt     = {1'b0, pend_note_r};
          o_d2_nxt     = {1'b0, pend_vel_r};
          o_d3_nxt     = d3_r;
          o_last_nxt   = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wet_r      <= UNITY;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      ofs_vld_r  <= '0;
      gain_vld_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        wet_r <= cfg_wr_data;
      end
      if (ofs_we) begin
        ofs_vld_r[AW'(idx8)] <= 1'b1;
      end
      if (gain_we) begin
        gain_vld_r[AW'(gain_idx)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_r     <= frame_nxt;
    count_r     <= count_nxt;
    status_r    <= status_nxt;
    d1_r        <= d1_nxt;
    d2_r        <= d2_nxt;
    d3_r        <= d3_nxt;
    base_r      <= base_nxt;
    voice_r     <= voice_nxt;
    root_ofs_r  <= root_ofs_nxt;
    note_r      <= note_nxt;
    pend_note_r <= pend_note_nxt;
    pend_vel_r  <= pend_vel_nxt;
    o_frame_r   <= o_frame_nxt;
    o_count_r   <= o_count_nxt;
    o_status_r  <= o_status_nxt;
    o_d1_r      <= o_d1_nxt;
    o_d2_r      <= o_d2_nxt;
    o_d3_r      <= o_d3_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_vld_r;
  assign out_chan.out_frame      = o_frame_r;
  assign out_chan.out_byte_count = o_count_r;
  assign out_chan.out_status     = o_status_r;
  assign out_chan.out_data_one   = o_d1_r;
  assign out_chan.out_data_two   = o_d2_r;
  assign out_chan.out_data_three = o_d3_r;
  assign out_chan.last           = o_last_r;

  // no voice may be left behind when a new item can come in
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !pend_vld_r)
    else $error("held voice still pending while ready");

  // a non-final result always has its successor held back
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> pend_vld_r)
    else $error("non-final result without a following voice");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ($past(state_r) == S_MUL2 || $past(state_r) == S_EMIT))
    else $error("emit step reached without second multiply");

  // the voice counter is only set up for note events
  a_voice_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_PASS) |-> (voice_r <= LAST_VOICE))
    else $error("voice counter beyond last voice");

endmodule
